// ===== rtl/atc_pkg.sv =====
// Shared types and constants for the averaged temperature compensation block.
package atc_pkg;

	localparam int DEF_MAX_WINDOW  = 64;
	localparam int DEF_SAMPLE_BITS = 20;
	localparam int MUL_BITS        = 32;
	localparam logic [6:0] FILTER_COUNT_RESET = 7'd8;

	typedef enum logic [1:0] {
		REG_FILTER_COUNT,
		REG_CAL_OFFSET,
		REG_CAL_LINEAR,
		REG_CAL_SQUARE
	} reg_index_t;

	typedef struct packed {
		logic [19:0] raw_sample;
	} sample_item_t;

	typedef struct packed {
		logic [19:0]        average_raw;
		logic signed [31:0] temp_centi;
	} result_item_t;

endpackage

// ===== rtl/atc_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per request.
interface atc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/atc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module atc_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/atc_smul.sv =====
// Bit-serial 32x32 multiplier, low 32 bits of the product, one bit per cycle.
module atc_smul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] prod
);
	localparam int CNT_W = $clog2(atc_pkg::MUL_BITS);

	logic [31:0]      a_q;
	logic [31:0]      b_q;
	logic [31:0]      acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			a_q    <= a;
			b_q    <= b;
			acc_q  <= '0;
			cnt_q  <= CNT_W'(atc_pkg::MUL_BITS - 1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			// add shifted multiplicand for the current multiplier bit
			acc_q <= acc_q + (b_q[0] ? a_q : 32'd0);
			a_q   <= {a_q[30:0], 1'b0};
			b_q   <= {1'b0, b_q[31:1]};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// ===== rtl/averaged_temperature_compensation.sv =====
// Top level: moving-average window with three-coefficient temperature compensation.
// Each accepted raw sample updates a circular window of the last filter_count samples
// and returns the floor average plus the compensated temperature in hundredths of a
// degree. Each sample is processed as follows:
// a restoring divider produces one quotient bit per cycle over the SAMPLE_BITS +
// clog2(MAX_WINDOW+1) bit window sum, then one bit-serial multiplier runs three 32-bit
// products one multiplier bit per cycle. One sample is in flight at a time; a finished
// result sits in an output register so the next sample is taken while it waits.
// Window refills after reset or a length change are done as the sample is accepted, with no extra states.
module averaged_temperature_compensation #(
	parameter int MAX_WINDOW  = atc_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = atc_pkg::DEF_SAMPLE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	atc_stream_if.sink   sample,
	atc_stream_if.source result
);
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W  = SAMPLE_BITS + LEN_W;
	localparam int DCNT_W = $clog2(SUM_W);

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_UPD, S_DIV, S_MUL1, S_MUL2, S_MUL3, S_FIN, S_DONE
	} state_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] k);
		return 32'($signed(x) >>> k);
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	function automatic logic [LEN_W-1:0] eff_len(input logic [6:0] fc);
		if (fc == 7'd0) begin
			return LEN_W'(1);
		end else if (int'(fc) > MAX_WINDOW) begin
			return LEN_W'(MAX_WINDOW);
		end
		return LEN_W'(fc);
	endfunction

	// configuration registers
	logic [6:0]  filter_count_q;
	logic [15:0] cal_offset_q;
	logic [15:0] cal_linear_q;
	logic [15:0] cal_square_q;
	logic        cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_count_q <= atc_pkg::FILTER_COUNT_RESET;
			cal_offset_q   <= '0;
			cal_linear_q   <= '0;
			cal_square_q   <= '0;
		end else if (cfg_wr) begin
			case (atc_pkg::reg_index_t'(paddr[3:2]))
				atc_pkg::REG_FILTER_COUNT: filter_count_q <= pwdata[6:0];
				atc_pkg::REG_CAL_OFFSET:   cal_offset_q   <= pwdata[15:0];
				atc_pkg::REG_CAL_LINEAR:   cal_linear_q   <= pwdata[15:0];
				atc_pkg::REG_CAL_SQUARE:   cal_square_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (atc_pkg::reg_index_t'(paddr[3:2]))
			atc_pkg::REG_FILTER_COUNT: prdata = {25'd0, filter_count_q};
			atc_pkg::REG_CAL_OFFSET:   prdata = {16'd0, cal_offset_q};
			atc_pkg::REG_CAL_LINEAR:   prdata = {16'd0, cal_linear_q};
			atc_pkg::REG_CAL_SQUARE:   prdata = {16'd0, cal_square_q};
			default:                   prdata = '0;
		endcase
	end

	// datapath state
	state_t                 state_q;
	logic                   primed_q;
	logic                   pending_q;
	logic [SUM_W-1:0]       sum_q;
	logic [ADDR_W-1:0]      slot_q;
	logic [LEN_W-1:0]       written_q;
	logic [SAMPLE_BITS-1:0] fill_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] last_avg_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [SUM_W-1:0]       div_q;
	logic [LEN_W-1:0]       rem_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic [31:0]            v1_q;
	logic [31:0]            fine_q;
	logic [31:0]            temp_q;
	logic                   mul_start_q;
	logic [31:0]            mul_a_q;
	logic [31:0]            mul_b_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_avg_q;
	logic [31:0]            out_temp_q;

	logic [LEN_W-1:0]       len;
	logic [SAMPLE_BITS-1:0] in_s;
	logic [SAMPLE_BITS-1:0] fill_v;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [SAMPLE_BITS-1:0] old_v;
	logic [SUM_W-1:0]       sum_next;
	logic [LEN_W-1:0]       slot_inc;
	logic [LEN_W:0]         trial;
	logic                   qbit;
	logic [SUM_W-1:0]       div_next;
	logic [SAMPLE_BITS-1:0] quot;
	logic                   mul_done;
	logic [31:0]            mul_prod;

	assign len      = eff_len(filter_count_q);
	assign in_s     = SAMPLE_BITS'(sample.data.raw_sample);
	assign fill_v   = primed_q ? last_avg_q : in_s;
	// slots not yet rewritten since the last fill read as the fill value
	assign old_v    = (LEN_W'(slot_q) < written_q) ? ram_rdata : fill_q;
	assign sum_next = sum_q - SUM_W'(old_v) + SUM_W'(sample_q);
	assign slot_inc = LEN_W'(slot_q) + 1'b1;
	assign trial    = {rem_q, div_q[SUM_W-1]};
	assign qbit     = (trial >= (LEN_W+1)'(len));
	assign div_next = {div_q[SUM_W-2:0], qbit};
	assign quot     = SAMPLE_BITS'(div_next);

	assign sample.ready = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.data.average_raw = 20'(out_avg_q);
	assign result.data.temp_centi  = out_temp_q;

	atc_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_window (
		.clk  (clk),
		.we   (state_q == S_UPD),
		.waddr(slot_q),
		.wdata(sample_q),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	atc_smul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start_q),
		.a     (mul_a_q),
		.b     (mul_b_q),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			primed_q    <= 1'b0;
			pending_q   <= 1'b0;
			sum_q       <= '0;
			slot_q      <= '0;
			written_q   <= '0;
			last_avg_q  <= '0;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// launch a product after the divide and after each of the first two products
			mul_start_q <= (state_q == S_DIV && dcnt_q == '0)
				|| ((state_q == S_MUL1 || state_q == S_MUL2) && mul_done);
			if (result.valid && result.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						sample_q <= in_s;
						if (!primed_q || pending_q) begin
							// fill the active window without touching the store
							fill_q    <= fill_v;
							sum_q     <= SUM_W'(fill_v) * SUM_W'(len);
							written_q <= '0;
							slot_q    <= '0;
							primed_q  <= 1'b1;
							pending_q <= 1'b0;
						end
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_UPD;
				S_UPD: begin
					sum_q  <= sum_next;
					div_q  <= sum_next;
					rem_q  <= '0;
					dcnt_q <= DCNT_W'(SUM_W - 1);
					if (written_q < len) begin
						written_q <= written_q + 1'b1;
					end
					slot_q  <= (slot_inc >= len) ? '0 : ADDR_W'(slot_inc);
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_q <= div_next;
					rem_q <= qbit ? LEN_W'(trial - (LEN_W+1)'(len)) : LEN_W'(trial);
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						avg_q       <= quot;
						last_avg_q  <= quot;
						mul_a_q     <= (32'(quot) >> 3) - (32'(cal_offset_q) << 1);
						mul_b_q     <= sext16(cal_linear_q);
						state_q     <= S_MUL1;
					end
				end
				S_MUL1: begin
					if (mul_done) begin
						v1_q        <= asr32(mul_prod, 5'd11);
						mul_a_q     <= (32'(avg_q) >> 4) - 32'(cal_offset_q);
						mul_b_q     <= (32'(avg_q) >> 4) - 32'(cal_offset_q);
						state_q     <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						mul_a_q     <= asr32(mul_prod, 5'd12);
						mul_b_q     <= sext16(cal_square_q);
						state_q     <= S_MUL3;
					end
				end
				S_MUL3: begin
					if (mul_done) begin
						fine_q  <= v1_q + asr32(mul_prod, 5'd14);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					temp_q  <= asr32((fine_q << 2) + fine_q + 32'd128, 5'd8);
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || result.ready) begin
						out_avg_q   <= avg_q;
						out_temp_q  <= temp_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_wr && atc_pkg::reg_index_t'(paddr[3:2]) == atc_pkg::REG_FILTER_COUNT
					&& eff_len(pwdata[6:0]) != len) begin
				pending_q <= 1'b1;
			end
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("second request accepted while a sample is in flight");

	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q && !pending_q |-> LEN_W'(slot_q) < len)
		else $error("write slot outside the active window");

	a_written_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> written_q <= len)
		else $error("written count exceeds window length");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < len)
		else $error("divider remainder not below divisor");
endmodule
